/* design/jcac_pkg.sv */
// Shared constants, types and codes for the joystick calibration and arming controller.
package jcac_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int CAL_BITS       = 3 * SAMPLE_BITS;
   localparam int NUM_AXES       = 4;
   localparam int AXIS_BITS      = 2;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROLL_CAL     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PITCH_CAL    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THROTTLE_CAL = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_YAW_CAL      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REARM_LIMIT  = 3'd4;

   localparam logic [AXIS_BITS-1:0] AXIS_ROLL     = 2'd0;
   localparam logic [AXIS_BITS-1:0] AXIS_PITCH    = 2'd1;
   localparam logic [AXIS_BITS-1:0] AXIS_THROTTLE = 2'd2;
   localparam logic [AXIS_BITS-1:0] AXIS_YAW      = 2'd3;

   localparam logic [CAL_BITS-1:0]    CAL_RESET   = 36'd8386559;
   localparam logic [SAMPLE_BITS-1:0] REARM_RESET = 12'd50;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic       start;
      sample_type raw;
      sample_type lo;
      sample_type mid;
      sample_type hi;
   } cal_cmd_type;

   typedef struct packed {
      logic       done;
      sample_type value;
   } cal_rsp_type;

endpackage

/* design/jcac_cal.sv */
// Iterative single-axis calibration unit: piecewise-linear remap with a shared restoring divider.
module jcac_cal (
   input  logic                  clock,
   input  logic                  reset,
   input  jcac_pkg::cal_cmd_type cmd,
   output jcac_pkg::cal_rsp_type rsp
);

   localparam int SB = jcac_pkg::SAMPLE_BITS;
   localparam int DW = SB + 3;
   localparam int SW = SB + 1;
   localparam int NW = 2 * SB + 1;
   localparam int CW = $clog2(SB);

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_NORM = 2'd1;
   localparam logic [1:0] C_LOAD = 2'd2;
   localparam logic [1:0] C_DIV  = 2'd3;

   localparam logic [SB-1:0] FULL = {SB{1'b1}};
   localparam logic [SB-1:0] HALF = {1'b0, {(SB-1){1'b1}}};

   logic [1:0]           state_ff, state_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic signed [SW-1:0] s_ff, s_in;
   logic                 below_ff, below_in;
   logic                 above_ff, above_in;
   logic [SB:0]          dn_ff, dn_in;
   logic [SB:0]          den_ff, den_in;
   logic [SB:0]          rem_ff, rem_in;
   logic [SB-1:0]        low_ff, low_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [SB-1:0]        value_ff, value_in;

   logic signed [DW-1:0] raw_x, lo_x, mid_x, hi_x;
   logic signed [DW-1:0] s_full;
   logic signed [DW-1:0] dn_s;
   logic signed [SW-1:0] sn_s;
   logic [SB:0]          den_norm;
   logic signed [DW-1:0] den_x;
   logic [NW-1:0]        num;
   logic [SB+1:0]        rem2;
   logic [SB+1:0]        rem_sub;
   logic                 ge;

   always_comb begin
      raw_x  = $signed({3'b000, cmd.raw});
      lo_x   = $signed({3'b000, cmd.lo});
      mid_x  = $signed({3'b000, cmd.mid});
      hi_x   = $signed({3'b000, cmd.hi});
      s_full = (cmd.raw < cmd.mid) ? (mid_x - lo_x) : (hi_x - mid_x);

      dn_s     = s_ff[SW-1] ? -d_ff : d_ff;
      sn_s     = s_ff[SW-1] ? -s_ff : s_ff;
      den_norm = {sn_s[SB-1:0], 1'b0};
      den_x    = $signed({2'b00, den_norm});

      num     = {dn_ff, {SB{1'b0}}} - {{SB{1'b0}}, dn_ff};
      rem2    = {rem_ff, low_ff[SB-1]};
      ge      = rem2 >= {1'b0, den_ff};
      rem_sub = rem2 - {1'b0, den_ff};
   end

   always_comb begin
      state_in = state_ff;
      d_in     = d_ff;
      s_in     = s_ff;
      below_in = below_ff;
      above_in = above_ff;
      dn_in    = dn_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (cmd.start) begin
               below_in = cmd.raw < cmd.mid;
               above_in = cmd.raw > cmd.mid;
               d_in     = (cmd.raw < cmd.mid) ? (raw_x - lo_x)
                                              : (raw_x + hi_x - (mid_x <<< 1));
               s_in     = s_full[SW-1:0];
               state_in = C_NORM;
            end
         end
         C_NORM: begin
            dn_in  = dn_s[SB:0];
            den_in = den_norm;
            if (s_ff == '0) begin
               done_in  = 1'b1;
               value_in = below_ff ? '0 : (above_ff ? FULL : HALF);
               state_in = C_IDLE;
            end else if (dn_s <= 0) begin
               done_in  = 1'b1;
               value_in = '0;
               state_in = C_IDLE;
            end else if (dn_s >= den_x) begin
               done_in  = 1'b1;
               value_in = FULL;
               state_in = C_IDLE;
            end else begin
               state_in = C_LOAD;
            end
         end
         C_LOAD: begin
            rem_in   = num[NW-1:SB];
            low_in   = num[SB-1:0];
            cnt_in   = '0;
            state_in = C_DIV;
         end
         C_DIV: begin
            rem_in = ge ? rem_sub[SB:0] : rem2[SB:0];
            low_in = {low_ff[SB-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(SB - 1)) begin
               done_in  = 1'b1;
               value_in = {low_ff[SB-2:0], ge};
               state_in = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      d_ff     <= d_in;
      s_ff     <= s_in;
      below_ff <= below_in;
      above_ff <= above_in;
      dn_ff    <= dn_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      cnt_ff   <= cnt_in;
      value_ff <= value_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule

/* design/joystick_cal_arm_controller.sv */
// Joystick calibration and arming controller: top level with sequencer and state flags.
// Sequencing: with tick, the four axes pass in turn through one shared calibration unit, each
// through start, normalize, load, 12 divide steps and result, or settled early by a zero span
// or a clamp; the response is then registered. Without tick, the response is registered directly.
// A new request is taken only once the last one has reached its response; a held response stalls.
// Reset: synchronous, active high; clears flags and pending bits, loads register defaults.
module joystick_cal_arm_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_tick,
   input  logic                                req_mode_press,
   input  logic                                req_emergency_press,
   input  logic [jcac_pkg::SAMPLE_BITS-1:0]    req_roll_raw,
   input  logic [jcac_pkg::SAMPLE_BITS-1:0]    req_pitch_raw,
   input  logic [jcac_pkg::SAMPLE_BITS-1:0]    req_throttle_raw,
   input  logic [jcac_pkg::SAMPLE_BITS-1:0]    req_yaw_raw,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_send_packet,
   output logic                                rsp_mode_out,
   output logic [jcac_pkg::SAMPLE_BITS-1:0]    rsp_throttle_out,
   output logic [jcac_pkg::SAMPLE_BITS-1:0]    rsp_pitch_out,
   output logic [jcac_pkg::SAMPLE_BITS-1:0]    rsp_roll_out,
   output logic [jcac_pkg::SAMPLE_BITS-1:0]    rsp_yaw_out,
   output logic                                rsp_armed_now,
   output logic                                rsp_emergency_now,
   output logic                                rsp_led_on,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [jcac_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [jcac_pkg::CAL_BITS-1:0]       csr_data
);

   localparam int SB = jcac_pkg::SAMPLE_BITS;
   localparam int NA = jcac_pkg::NUM_AXES;
   localparam int AB = jcac_pkg::AXIS_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [jcac_pkg::CAL_BITS-1:0] cal_ff [NA];
   logic [SB-1:0]                 rearm_ff;
   logic [SB-1:0]                 raw_ff [NA];
   logic [SB-1:0]                 res_ff [NA];

   logic [1:0]    state_ff, state_in;
   logic [AB-1:0] axis_ff, axis_in;
   logic          start_ff, start_in;
   logic          tick_ff, mpress_ff, epress_ff;
   logic          mode_ff, mode_in;
   logic          armed_ff, armed_in;
   logic          emerg_ff, emerg_in;
   logic          mpend_ff, mpend_in;
   logic          epend_ff, epend_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          send_ff, send_in;
   logic          mout_ff, mout_in;
   logic [SB-1:0] thr_ff, thr_in;
   logic [SB-1:0] pit_ff, pit_in;
   logic [SB-1:0] rol_ff, rol_in;
   logic [SB-1:0] yaw_ff, yaw_in;

   logic req_fire;
   logic fin_go;
   logic [jcac_pkg::CAL_BITS-1:0] cal_sel;

   jcac_pkg::cal_cmd_type cal_cmd;
   jcac_pkg::cal_rsp_type cal_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign fin_go    = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   assign cal_sel       = cal_ff[axis_ff];
   assign cal_cmd.start = start_ff;
   assign cal_cmd.raw   = raw_ff[axis_ff];
   assign cal_cmd.lo    = cal_sel[SB-1:0];
   assign cal_cmd.mid   = cal_sel[2*SB-1:SB];
   assign cal_cmd.hi    = cal_sel[3*SB-1:2*SB];

   jcac_cal u_cal (
      .clock (clock),
      .reset (reset),
      .cmd   (cal_cmd),
      .rsp   (cal_rsp)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      start_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               axis_in = jcac_pkg::AXIS_ROLL;
               if (req_tick) begin
                  start_in = 1'b1;
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_RUN: begin
            if (cal_rsp.done) begin
               if (axis_ff == jcac_pkg::AXIS_YAW) begin
                  state_in = ST_FIN;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  start_in = 1'b1;
               end
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // event handling, arming and packet build
   always_comb begin
      logic          mp, ep, md, ar, em, snd;
      logic [SB-1:0] t;
      mp  = mpend_ff | mpress_ff;
      ep  = epend_ff | epress_ff;
      md  = mode_ff;
      ar  = armed_ff;
      em  = emerg_ff;
      snd = 1'b0;
      t   = res_ff[jcac_pkg::AXIS_THROTTLE];
      if (mp && ar) begin
         md = ~md;
         mp = 1'b0;
      end
      if (ep && ar) begin
         em = 1'b1;
         mp = 1'b0;
         ep = 1'b0;
      end
      if (tick_ff) begin
         if (!ar && mp && ep) begin
            if (!em) begin
               ar = 1'b1;
            end else if (t < rearm_ff) begin
               em = 1'b0;
               ar = 1'b1;
            end
            if (ar) begin
               mp = 1'b0;
               ep = 1'b0;
            end
         end
         if (ar) begin
            snd = 1'b1;
         end
         if (em) begin
            ar = 1'b0;
         end
      end
      mode_in  = md;
      armed_in = ar;
      emerg_in = em;
      mpend_in = mp;
      epend_in = ep;
      send_in  = snd;
      mout_in  = snd & md;
      thr_in   = (snd && !em) ? t : '0;
      pit_in   = snd ? res_ff[jcac_pkg::AXIS_PITCH] : '0;
      rol_in   = snd ? res_ff[jcac_pkg::AXIS_ROLL] : '0;
      yaw_in   = snd ? res_ff[jcac_pkg::AXIS_YAW] : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= jcac_pkg::AXIS_ROLL;
         start_ff     <= 1'b0;
         mode_ff      <= 1'b0;
         armed_ff     <= 1'b0;
         emerg_ff     <= 1'b0;
         mpend_ff     <= 1'b0;
         epend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rearm_ff     <= jcac_pkg::REARM_RESET;
         for (int i = 0; i < NA; i++) begin
            cal_ff[i] <= jcac_pkg::CAL_RESET;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fin_go) begin
            mode_ff  <= mode_in;
            armed_ff <= armed_in;
            emerg_ff <= emerg_in;
            mpend_ff <= mpend_in;
            epend_ff <= epend_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               jcac_pkg::CSR_ROLL_CAL:     cal_ff[jcac_pkg::AXIS_ROLL]     <= csr_data;
               jcac_pkg::CSR_PITCH_CAL:    cal_ff[jcac_pkg::AXIS_PITCH]    <= csr_data;
               jcac_pkg::CSR_THROTTLE_CAL: cal_ff[jcac_pkg::AXIS_THROTTLE] <= csr_data;
               jcac_pkg::CSR_YAW_CAL:      cal_ff[jcac_pkg::AXIS_YAW]      <= csr_data;
               jcac_pkg::CSR_REARM_LIMIT:  rearm_ff <= csr_data[SB-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload: request capture, axis results, response fields
   always_ff @(posedge clock) begin
      if (req_fire) begin
         tick_ff   <= req_tick;
         mpress_ff <= req_mode_press;
         epress_ff <= req_emergency_press;
         raw_ff[jcac_pkg::AXIS_ROLL]     <= req_roll_raw;
         raw_ff[jcac_pkg::AXIS_PITCH]    <= req_pitch_raw;
         raw_ff[jcac_pkg::AXIS_THROTTLE] <= req_throttle_raw;
         raw_ff[jcac_pkg::AXIS_YAW]      <= req_yaw_raw;
      end
      if (state_ff == ST_RUN && cal_rsp.done) begin
         res_ff[axis_ff] <= cal_rsp.value;
      end
      if (fin_go) begin
         send_ff <= send_in;
         mout_ff <= mout_in;
         thr_ff  <= thr_in;
         pit_ff  <= pit_in;
         rol_ff  <= rol_in;
         yaw_ff  <= yaw_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_packet   = send_ff;
   assign rsp_mode_out      = mout_ff;
   assign rsp_throttle_out  = thr_ff;
   assign rsp_pitch_out     = pit_ff;
   assign rsp_roll_out      = rol_ff;
   assign rsp_yaw_out       = yaw_ff;
   assign rsp_armed_now     = armed_ff;
   assign rsp_emergency_now = emerg_ff;
   assign rsp_led_on        = mode_ff;

`ifndef SYNTHESIS
   a_no_packet_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_packet |->
         !rsp_mode_out && rsp_throttle_out == '0 && rsp_pitch_out == '0 &&
         rsp_roll_out == '0 && rsp_yaw_out == '0)
      else $error("fields nonzero without packet");

   a_emerg_throttle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_packet && rsp_emergency_now |-> rsp_throttle_out == '0)
      else $error("throttle not forced to zero in emergency");

   a_packet_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_packet |-> rsp_mode_out == rsp_led_on)
      else $error("packet mode differs from lamp");

   a_cal_done_run: assert property (@(posedge clock) disable iff (reset)
      cal_rsp.done |-> state_ff == ST_RUN)
      else $error("calibration result outside run phase");
`endif

endmodule

/* sim/joystick_cal_arm_checker.sv */
// Checker for the joystick calibration and arming controller: predicts and compares responses.
module joystick_cal_arm_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_tick,
   input  logic                                req_mode_press,
   input  logic                                req_emergency_press,
   input  logic [jcac_pkg::SAMPLE_BITS-1:0]    req_roll_raw,
   input  logic [jcac_pkg::SAMPLE_BITS-1:0]    req_pitch_raw,
   input  logic [jcac_pkg::SAMPLE_BITS-1:0]    req_throttle_raw,
   input  logic [jcac_pkg::SAMPLE_BITS-1:0]    req_yaw_raw,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_send_packet,
   input  logic                                rsp_mode_out,
   input  logic [jcac_pkg::SAMPLE_BITS-1:0]    rsp_throttle_out,
   input  logic [jcac_pkg::SAMPLE_BITS-1:0]    rsp_pitch_out,
   input  logic [jcac_pkg::SAMPLE_BITS-1:0]    rsp_roll_out,
   input  logic [jcac_pkg::SAMPLE_BITS-1:0]    rsp_yaw_out,
   input  logic                                rsp_armed_now,
   input  logic                                rsp_emergency_now,
   input  logic                                rsp_led_on,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [jcac_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [jcac_pkg::CAL_BITS-1:0]       csr_data,
   output int                                  fail_count,
   output int                                  responses_seen
);

   import jcac_pkg::*;

   localparam longint FULL_CODE = (longint'(1) << SAMPLE_BITS) - 1;

   typedef struct packed {
      logic       send_packet;
      logic       mode;
      sample_type throttle;
      sample_type pitch;
      sample_type roll;
      sample_type yaw;
      logic       armed;
      logic       emergency;
      logic       led;
   } telemetry_type;

   logic [CAL_BITS-1:0] axis_cal [NUM_AXES];
   sample_type          rearm_level;
   logic                mode_flag, armed, emergency, mode_pending, emergency_pending;
   telemetry_type       telemetry_q [$];
   telemetry_type       want;

   initial fail_count = 0;
   initial responses_seen = 0;

   task automatic report(input string msg);
      fail_count++;
      $display("ERROR: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [SAMPLE_BITS-1:0] got,
                              input logic [SAMPLE_BITS-1:0] exp_value);
      if (got !== exp_value)
         report($sformatf("response %0d %s: got %0d expected %0d",
                          responses_seen, name, got, exp_value));
   endtask

   function automatic sample_type map_axis(input sample_type raw, input logic [CAL_BITS-1:0] cal);
      longint s, lo, mid, hi, span, num, den;
      s   = longint'(raw);
      lo  = longint'(cal[SAMPLE_BITS-1:0]);
      mid = longint'(cal[2*SAMPLE_BITS-1:SAMPLE_BITS]);
      hi  = longint'(cal[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
      if (s < mid) begin
         span = mid - lo;
         if (span == 0) return '0;
         num = (s - lo) * FULL_CODE;
      end else begin
         span = hi - mid;
         if (span == 0) return (s > mid) ? sample_type'(FULL_CODE) : sample_type'(FULL_CODE / 2);
         num = FULL_CODE * span + (s - mid) * FULL_CODE;
      end
      den = 2 * span;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num < 0) return '0;
      num = num / den;
      return (num > FULL_CODE) ? sample_type'(FULL_CODE) : sample_type'(num);
   endfunction

   function automatic telemetry_type predict_wake();
      telemetry_type res;
      res = '0;
      mode_pending      = mode_pending | req_mode_press;
      emergency_pending = emergency_pending | req_emergency_press;
      if (mode_pending && armed) begin
         mode_flag    = ~mode_flag;
         mode_pending = 1'b0;
      end
      if (emergency_pending && armed) begin
         emergency         = 1'b1;
         mode_pending      = 1'b0;
         emergency_pending = 1'b0;
      end
      if (req_tick) begin
         res.roll     = map_axis(req_roll_raw, axis_cal[AXIS_ROLL]);
         res.pitch    = map_axis(req_pitch_raw, axis_cal[AXIS_PITCH]);
         res.throttle = map_axis(req_throttle_raw, axis_cal[AXIS_THROTTLE]);
         res.yaw      = map_axis(req_yaw_raw, axis_cal[AXIS_YAW]);
         if (!armed && mode_pending && emergency_pending) begin
            if (!emergency) begin
               armed = 1'b1;
            end else if (res.throttle < rearm_level) begin
               emergency = 1'b0;
               armed     = 1'b1;
            end
            if (armed) begin
               mode_pending      = 1'b0;
               emergency_pending = 1'b0;
            end
         end
         if (armed) begin
            res.send_packet = 1'b1;
            res.mode        = mode_flag;
            if (emergency) res.throttle = '0;
         end
         if (emergency) armed = 1'b0;
      end
      if (!res.send_packet) begin
         res.roll     = '0;
         res.pitch    = '0;
         res.throttle = '0;
         res.yaw      = '0;
         res.mode     = 1'b0;
      end
      res.armed     = armed;
      res.emergency = emergency;
      res.led       = mode_flag;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) axis_cal[a] = CAL_RESET;
         rearm_level       = REARM_RESET;
         mode_flag         = 1'b0;
         armed             = 1'b0;
         emergency         = 1'b0;
         mode_pending      = 1'b0;
         emergency_pending = 1'b0;
         telemetry_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROLL_CAL:     axis_cal[AXIS_ROLL]     = csr_data;
               CSR_PITCH_CAL:    axis_cal[AXIS_PITCH]    = csr_data;
               CSR_THROTTLE_CAL: axis_cal[AXIS_THROTTLE] = csr_data;
               CSR_YAW_CAL:      axis_cal[AXIS_YAW]      = csr_data;
               CSR_REARM_LIMIT:  rearm_level             = csr_data[SAMPLE_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (telemetry_q.size() == 0) begin
               report($sformatf("response %0d arrived with no request outstanding",
                                responses_seen));
            end else begin
               want = telemetry_q.pop_front();
               check_field("send_packet", rsp_send_packet, want.send_packet);
               check_field("mode_out", rsp_mode_out, want.mode);
               check_field("throttle_out", rsp_throttle_out, want.throttle);
               check_field("pitch_out", rsp_pitch_out, want.pitch);
               check_field("roll_out", rsp_roll_out, want.roll);
               check_field("yaw_out", rsp_yaw_out, want.yaw);
               check_field("armed_now", rsp_armed_now, want.armed);
               check_field("emergency_now", rsp_emergency_now, want.emergency);
               check_field("led_on", rsp_led_on, want.led);
            end
            responses_seen <= responses_seen + 1;
         end
         if (req_valid && req_ready) telemetry_q.push_back(predict_wake());
      end
   end

endmodule

/* sim/joystick_cal_arm_controller_test.sv */
// Testbench top for the joystick calibration and arming controller: stimulus and verdict.
module joystick_cal_arm_controller_test;

   import jcac_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_tick;
   logic                      req_mode_press;
   logic                      req_emergency_press;
   sample_type                req_roll_raw;
   sample_type                req_pitch_raw;
   sample_type                req_throttle_raw;
   sample_type                req_yaw_raw;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_send_packet;
   logic                      rsp_mode_out;
   sample_type                rsp_throttle_out;
   sample_type                rsp_pitch_out;
   sample_type                rsp_roll_out;
   sample_type                rsp_yaw_out;
   logic                      rsp_armed_now;
   logic                      rsp_emergency_now;
   logic                      rsp_led_on;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CAL_BITS-1:0]       csr_data;

   int                        fail_count;
   int                        responses_seen;
   int                        requests_sent = 0;
   bit                        steady = 1'b0;
   logic [CAL_BITS-1:0]       cal_set [NUM_AXES];
   sample_type                limit_set;

   int                        stall_left = 0;
   int                        stretch_left = 0;
   bit                        rsp_calm = 1'b0;

   joystick_cal_arm_controller dut (.*);

   joystick_cal_arm_checker checker_inst (.*);

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // hold or release the response side in random stretches
   always @(posedge clock) begin
      if (stretch_left == 0) begin
         stretch_left <= $urandom_range(200, 2000);
         rsp_calm     <= ($urandom_range(0, 2) == 0);
      end else begin
         stretch_left <= stretch_left - 1;
      end
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!rsp_calm && $urandom_range(0, 99) < 20) begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic int pick_gap();
      int k;
      if (steady) return 0;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_wake(input logic tick, input logic mode_press, input logic emergency_press,
                            input sample_type roll, input sample_type pitch,
                            input sample_type throttle, input sample_type yaw);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_tick            <= tick;
      req_mode_press      <= mode_press;
      req_emergency_press <= emergency_press;
      req_roll_raw        <= roll;
      req_pitch_raw       <= pitch;
      req_throttle_raw    <= throttle;
      req_yaw_raw         <= yaw;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // drop valid and wait until every request has its response
   task automatic settle();
      req_valid <= 1'b0;
      while (responses_seen != requests_sent) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CAL_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings();
      logic [CSR_INDEX_BITS-1:0] spare;
      logic [63:0]               noise;
      noise = {$urandom, $urandom};
      write_reg(CSR_ROLL_CAL, cal_set[AXIS_ROLL]);
      write_reg(CSR_PITCH_CAL, cal_set[AXIS_PITCH]);
      write_reg(CSR_THROTTLE_CAL, cal_set[AXIS_THROTTLE]);
      write_reg(CSR_YAW_CAL, cal_set[AXIS_YAW]);
      write_reg(CSR_REARM_LIMIT, {noise[CAL_BITS-SAMPLE_BITS-1:0], limit_set});
      if ($urandom_range(0, 3) == 0) begin
         spare = CSR_REARM_LIMIT + CSR_INDEX_BITS'($urandom_range(1, 3));
         write_reg(spare, noise[CAL_BITS-1:0]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CAL_BITS-1:0] make_cal();
      sample_type  lo, mid, hi;
      logic [63:0] w;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            lo  = sample_type'($urandom_range(0, 1400));
            mid = sample_type'($urandom_range(lo + 1, 2700));
            hi  = sample_type'($urandom_range(mid + 1, 4095));
         end
         3: begin
            lo  = sample_type'($urandom_range(0, 4095));
            mid = lo;
            hi  = sample_type'($urandom_range(mid, 4095));
         end
         4: begin
            mid = sample_type'($urandom_range(0, 4095));
            hi  = mid;
            lo  = sample_type'($urandom_range(0, mid));
         end
         5: begin
            hi  = sample_type'($urandom_range(0, 1400));
            mid = sample_type'($urandom_range(hi + 1, 2700));
            lo  = sample_type'($urandom_range(mid + 1, 4095));
         end
         6: begin
            w = {$urandom, $urandom};
            return w[CAL_BITS-1:0];
         end
         7: return '0;
         8: return '1;
         default: begin
            lo  = '0;
            mid = 12'd2047;
            hi  = '1;
         end
      endcase
      return {hi, mid, lo};
   endfunction

   function automatic sample_type pick_sample(input logic [CAL_BITS-1:0] cal);
      case ($urandom_range(0, 11))
         0: return '0;
         1: return '1;
         2: return cal[SAMPLE_BITS-1:0];
         3: return cal[2*SAMPLE_BITS-1:SAMPLE_BITS];
         4: return cal[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
         5: return cal[2*SAMPLE_BITS-1:SAMPLE_BITS] + sample_type'($urandom_range(0, 6)) - 12'd3;
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic random_wake();
      sample_type thr;
      if ($urandom_range(0, 3) == 0) thr = cal_set[AXIS_THROTTLE][SAMPLE_BITS-1:0];
      else thr = pick_sample(cal_set[AXIS_THROTTLE]);
      send_wake($urandom_range(0, 99) < 60, $urandom_range(0, 99) < 22,
                $urandom_range(0, 99) < 14, pick_sample(cal_set[AXIS_ROLL]),
                pick_sample(cal_set[AXIS_PITCH]), thr, pick_sample(cal_set[AXIS_YAW]));
   endtask

   initial begin
      #12000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_tick            = 1'b0;
      req_mode_press      = 1'b0;
      req_emergency_press = 1'b0;
      req_roll_raw        = '0;
      req_pitch_raw       = '0;
      req_throttle_raw    = '0;
      req_yaw_raw         = '0;
      csr_valid           = 1'b0;
      csr_index           = CSR_ROLL_CAL;
      csr_data            = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset calibration: not armed, then arm from idle
      send_wake(1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
      send_wake(1'b1, 1'b1, 1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
      settle();

      // roll zero span below, pitch inverted, throttle ordered, yaw zero span above
      cal_set[AXIS_ROLL]     = {12'd3000, 12'd1000, 12'd1000};
      cal_set[AXIS_PITCH]    = {12'd500, 12'd2000, 12'd3000};
      cal_set[AXIS_THROTTLE] = {12'd4000, 12'd2048, 12'd100};
      cal_set[AXIS_YAW]      = {12'd3500, 12'd3500, 12'd200};
      limit_set              = REARM_RESET;
      load_settings();
      send_wake(1'b1, 1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0);
      send_wake(1'b0, 1'b1, 1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
      send_wake(1'b1, 1'b0, 1'b0, 12'd999, 12'd2000, 12'd100, 12'd3499);
      send_wake(1'b1, 1'b0, 1'b0, 12'd1000, 12'd2500, 12'd4095, 12'd3500);
      send_wake(1'b1, 1'b0, 1'b0, 12'd4095, 12'd0, 12'd2048, 12'd4095);
      send_wake(1'b0, 1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
      send_wake(1'b1, 1'b0, 1'b0, 12'd3000, 12'd500, 12'd4000, 12'd0);
      send_wake(1'b0, 1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
      send_wake(1'b1, 1'b1, 1'b0, 12'd2000, 12'd3000, 12'd50, 12'd200);
      send_wake(1'b1, 1'b0, 1'b1, 12'd1500, 12'd1500, 12'd3000, 12'd1000);
      send_wake(1'b1, 1'b0, 1'b0, 12'd1500, 12'd1500, 12'd3000, 12'd1000);
      send_wake(1'b1, 1'b1, 1'b1, 12'd2047, 12'd2047, 12'd3000, 12'd2047);
      send_wake(1'b0, 1'b0, 1'b0, 12'd2047, 12'd2047, 12'd0, 12'd2047);
      send_wake(1'b1, 1'b0, 1'b0, 12'd2047, 12'd2047, 12'd0, 12'd2047);
      send_wake(1'b1, 1'b1, 1'b1, 12'd100, 12'd100, 12'd2048, 12'd100);
      send_wake(1'b0, 1'b1, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0);
      send_wake(1'b1, 1'b0, 1'b0, 12'd100, 12'd3000, 12'd100, 12'd3600);
      send_wake(1'b1, 1'b0, 1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
      send_wake(1'b1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
      settle();

      for (int phase = 0; phase < 16; phase++) begin
         steady = ($urandom_range(0, 3) == 0);
         for (int a = 0; a < NUM_AXES; a++) begin
            if (phase == 1) cal_set[a] = '0;
            else if (phase == 2) cal_set[a] = '1;
            else cal_set[a] = make_cal();
         end
         case ($urandom_range(0, 7))
            0: limit_set = '0;
            1: limit_set = '1;
            2: limit_set = REARM_RESET;
            3, 4: limit_set = sample_type'($urandom_range(0, 200));
            default: limit_set = sample_type'($urandom_range(0, 4095));
         endcase
         if (phase == 1) limit_set = '0;
         if (phase == 2) limit_set = '1;
         load_settings();
         for (int n = 0; n < 100; n++) random_wake();
         settle();
      end

      repeat (70) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
